FILE: hdl/aes128_block_cipher_ecb_cbc_assert.svh
// Assertion macros shared by the AES-128 checker.
// Plain text macros only; no dependencies.
`ifndef AES128_BLOCK_CIPHER_ECB_CBC_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ECB_CBC_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hdl/aes_pkg.sv
// Package for the AES-128 ECB/CBC core: types, S-boxes, round helpers.
// No dependencies.
package aes_pkg;
	localparam int unsigned NR = 10;
	localparam int unsigned RK_DEPTH = 2 * (NR + 1);

	typedef enum logic [2:0] {
		CFG_KEY_HIGH = 3'd0,
		CFG_KEY_LOW  = 3'd1,
		CFG_IV_HIGH  = 3'd2,
		CFG_IV_LOW   = 3'd3,
		CFG_MODE     = 3'd4,
		CFG_DIR      = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEYX,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       start;
		logic       decrypt;
		logic [3:0] round;
		logic       busy;
	} core_ctl_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) p = p ^ x;
			x = xt(x);
		end
		return p;
	endfunction

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] ISBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// byte i of a 128-bit word; byte 0 is the most significant
	function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
		return v[127 - 8 * i -: 8];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
		logic [7:0] t [16];
		logic [7:0] o [16];
		logic [127:0] r;
		for (int rr = 0; rr < 4; rr++)
			for (int c = 0; c < 4; c++)
				t[rr + 4 * c] = SBOX[byte_at(s, rr + 4 * ((c + rr) % 4))];
		for (int c = 0; c < 4; c++) begin
			if (last) begin
				for (int rr = 0; rr < 4; rr++) o[4 * c + rr] = t[4 * c + rr];
			end else begin
				for (int rr = 0; rr < 4; rr++)
					o[4 * c + rr] = gmul(t[4 * c + rr], 8'd2)
						^ gmul(t[4 * c + (rr + 1) % 4], 8'd3)
						^ t[4 * c + (rr + 2) % 4] ^ t[4 * c + (rr + 3) % 4];
			end
		end
		for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = o[i];
		return r;
	endfunction

	// inverse mix (unless first), inverse shift, inverse sub
	function automatic logic [127:0] dec_round(input logic [127:0] s, input logic first);
		logic [7:0] m [16];
		logic [7:0] t [16];
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int rr = 0; rr < 4; rr++) begin
				if (first) m[4 * c + rr] = byte_at(s, 4 * c + rr);
				else m[4 * c + rr] = gmul(byte_at(s, 4 * c + rr), 8'd14)
					^ gmul(byte_at(s, 4 * c + (rr + 1) % 4), 8'd11)
					^ gmul(byte_at(s, 4 * c + (rr + 2) % 4), 8'd13)
					^ gmul(byte_at(s, 4 * c + (rr + 3) % 4), 8'd9);
			end
		for (int rr = 0; rr < 4; rr++)
			for (int c = 0; c < 4; c++)
				t[rr + 4 * ((c + rr) % 4)] = ISBOX[m[rr + 4 * c]];
		for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
		return r;
	endfunction
endpackage

FILE: hdl/aes128_block_cipher_ecb_cbc.sv
// AES-128 block cipher (FIPS-197), ECB or CBC, one 128-bit block per request. A block is taken
// only while the core is idle and the key schedule is complete. It then passes through the
// shared round unit (initial key add plus ten rounds) and is then loaded into the output
// register; the next block is taken only once that load is done. A result the sink
// has not yet taken holds the next finished block in the round unit, and input stays blocked
// until the output register frees. Writing either key register restarts key expansion, which
// holds off input until it completes (also after reset). s_tdata: block_high [63:0],
// block_low [127:64]; s_tuser: first_block, which restarts chaining from the IV. Write the
// configuration only while no block is in flight.
module aes128_block_cipher_ecb_cbc (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
	input  logic         s_tuser,   // first_block
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // result_high [63:0], result_low [127:64]
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [63:0]  cfg_data
);
	logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic         mode_q, dir_q, dec_q;
	logic [127:0] chain_q, in_q, out_q;
	logic         ovalid_q;
	logic [3:0]   rnd_q;
	aes_pkg::state_t st_q, st_d;
	aes_pkg::core_ctl_t ctl;
	logic         kx_start, kx_busy, acc, ld_out;
	logic [127:0] rkey, core_st, blk, din, chain_use, res;
	logic [3:0]   rd_round;

	assign blk = {s_tdata[63:0], s_tdata[127:64]};
	assign acc = s_tvalid && s_tready;
	assign chain_use = s_tuser ? {iv_hi_q, iv_lo_q} : chain_q;
	assign din = (!dir_q && mode_q) ? (blk ^ chain_use) : blk;
	assign kx_start = cfg_we && (cfg_idx == aes_pkg::CFG_KEY_HIGH
		|| cfg_idx == aes_pkg::CFG_KEY_LOW);
	// move the finished block out once the output register is free or being emptied
	assign ld_out = (st_q == aes_pkg::ST_DONE) && (!ovalid_q || m_tready);

	always_comb begin
		if (acc) rd_round = dir_q ? 4'(aes_pkg::NR) : 4'd0;
		else rd_round = dec_q ? 4'(aes_pkg::NR) - rnd_q : rnd_q;
	end

	assign ctl = '{start: acc, decrypt: dec_q, round: rnd_q,
		busy: (st_q == aes_pkg::ST_RUN)};

	aes_keyx u_keyx (
		.clk(clk), .arst_n(arst_n), .start(kx_start),
		.key({cfg_idx == aes_pkg::CFG_KEY_HIGH ? cfg_data : key_hi_q,
			cfg_idx == aes_pkg::CFG_KEY_LOW ? cfg_data : key_lo_q}),
		.rd_round(rd_round), .rd_key(rkey), .busy(kx_busy)
	);

	aes_round u_round (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .din(din), .rkey(rkey), .state(core_st)
	);

	assign s_tready = (st_q == aes_pkg::ST_IDLE) && !kx_busy;
	assign res = dec_q && mode_q ? core_st ^ chain_q : core_st;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			aes_pkg::ST_IDLE: if (acc) st_d = aes_pkg::ST_RUN;
			aes_pkg::ST_RUN:  if (rnd_q == 4'(aes_pkg::NR)) st_d = aes_pkg::ST_DONE;
			aes_pkg::ST_DONE: if (ld_out) st_d = aes_pkg::ST_IDLE;
			default:          st_d = aes_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= aes_pkg::ST_IDLE;
			key_hi_q <= '0; key_lo_q <= '0; iv_hi_q <= '0; iv_lo_q <= '0;
			mode_q <= 1'b0; dir_q <= 1'b0; dec_q <= 1'b0;
			chain_q <= '0; ovalid_q <= 1'b0; rnd_q <= 4'd0;
			in_q <= '0; out_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					aes_pkg::CFG_KEY_HIGH: key_hi_q <= cfg_data;
					aes_pkg::CFG_KEY_LOW:  key_lo_q <= cfg_data;
					aes_pkg::CFG_IV_HIGH:  iv_hi_q <= cfg_data;
					aes_pkg::CFG_IV_LOW:   iv_lo_q <= cfg_data;
					aes_pkg::CFG_MODE:     mode_q <= cfg_data[0];
					aes_pkg::CFG_DIR:      dir_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (acc) begin
				rnd_q <= 4'd1;
				dec_q <= dir_q;
				in_q <= blk;
				chain_q <= chain_use;
			end else if (st_q == aes_pkg::ST_RUN) begin
				rnd_q <= rnd_q + 4'd1;
			end
			if (ld_out) begin
				out_q <= res;
				ovalid_q <= 1'b1;
				chain_q <= dec_q ? in_q : core_st;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata = {out_q[63:0], out_q[127:64]};
endmodule

FILE: hdl/aes_keyx.sv
// Key expansion sequencer: one round key per cycle into a 11 x 128 register file.
// Depends on aes_pkg.
module aes_keyx (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [127:0]   key,
	input  logic [3:0]     rd_round,
	output logic [127:0]   rd_key,
	output logic           busy
);
	logic [127:0] rk_q [aes_pkg::NR + 1];
	logic [3:0]   idx_q;
	logic [7:0]   rc_q;
	logic         busy_q;
	logic [127:0] prev;
	logic [31:0]  t;
	logic [31:0]  w0, w1, w2, w3;

	assign prev = rk_q[idx_q - 4'd1];
	assign t = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rc_q, 24'h0};
	assign w0 = prev[127:96] ^ t;
	assign w1 = prev[95:64] ^ w0;
	assign w2 = prev[63:32] ^ w1;
	assign w3 = prev[31:0] ^ w2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q <= 4'd1;
			rc_q <= 8'h01;
			rk_q[0] <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q <= 4'd1;
			rc_q <= 8'h01;
			rk_q[0] <= key;
		end else if (busy_q) begin
			rk_q[idx_q] <= {w0, w1, w2, w3};
			rc_q <= aes_pkg::xt(rc_q);
			idx_q <= idx_q + 4'd1;
			if (idx_q == 4'(aes_pkg::NR)) busy_q <= 1'b0;
		end
	end

	assign rd_key = rk_q[rd_round];
	assign busy = busy_q;
endmodule

FILE: hdl/aes_round.sv
// Shared round unit: holds the 128-bit state and applies one round per cycle while busy.
// Depends on aes_pkg.
module aes_round (
	input  logic               clk,
	input  logic               arst_n,
	input  aes_pkg::core_ctl_t ctl,
	input  logic [127:0]       din,
	input  logic [127:0]       rkey,
	output logic [127:0]       state
);
	logic [127:0] st_q;
	logic [127:0] nxt;

	// decryption skips the inverse mix in its first round
	always_comb begin
		if (ctl.start) nxt = din ^ rkey;
		else if (!ctl.decrypt)
			nxt = aes_pkg::enc_round(st_q, ctl.round == 4'(aes_pkg::NR)) ^ rkey;
		else
			nxt = aes_pkg::dec_round(st_q, ctl.round == 4'd1) ^ rkey;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= '0;
		else if (ctl.start || ctl.busy) st_q <= nxt;
	end

	assign state = st_q;
endmodule

FILE: hdl/aes_checker.sv
// Port-level checker for the AES-128 core, bound to the top level.
// Depends on aes128_block_cipher_ecb_cbc_assert.svh.
`include "aes128_block_cipher_ecb_cbc_assert.svh"
module aes_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);
	`AES_ASSERT_NXT(a_busy_after_req, clk, arst_n, s_tvalid && s_tready, !s_tready [*11])
	`AES_ASSERT_IMP(a_known_out, clk, arst_n, m_tvalid, !$isunknown(m_tdata))
	`AES_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind aes128_block_cipher_ecb_cbc aes_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: verif/testbench.sv
// Self-checking testbench for the AES-128 ECB/CBC block cipher.
// Predicts every output block with a behavioral AES model; depends on aes_pkg and the RTL.
`timescale 1ns / 100ps
module testbench;
	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        first;
	} blk_req_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_idx;
	logic [63:0]  cfg_data;

	aes128_block_cipher_ecb_cbc i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// predictor state
	logic [7:0]   sb [256];
	logic [7:0]   isb [256];
	logic [127:0] key_q, iv_q, chain_q;
	logic [127:0] rk [11];
	logic         cbc_q, dec_q;

	blk_req_t     pending_blocks [$];
	logic [127:0] expected_blocks [$];
	int           errors = 0;
	int           n_checked = 0;
	int           n_sent = 0;
	int           hold_off = 0;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = xtime(a);
		end
		return p;
	endfunction

	// S-box from the field inverse and affine map
	task automatic build_sboxes();
		logic [7:0] inv, base, b;
		int e;
		for (int x = 0; x < 256; x++) begin
			inv = 8'd1;
			base = 8'(x);
			e = 254;
			while (e != 0) begin
				if (e & 1) inv = gf_product(inv, base);
				base = gf_product(base, base);
				e >>= 1;
			end
			if (x == 0) inv = 8'd0;
			b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			sb[x] = b;
			isb[b] = 8'(x);
		end
	endtask

	task automatic expand_round_keys();
		logic [31:0] w [44];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'd1;
		for (int i = 0; i < 4; i++) w[i] = key_q[127 - 32 * i -: 32];
		for (int i = 4; i < 44; i++) begin
			t = w[i - 1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {sb[t[31:24]], sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]} ^ {rc, 24'h0};
				rc = xtime(rc);
			end
			w[i] = w[i - 4] ^ t;
		end
		for (int r = 0; r < 11; r++) rk[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
	endtask

	function automatic logic [127:0] cipher_block(input logic [127:0] v, input logic inverse);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] m [4];
		logic [127:0] o;
		int r;
		for (int i = 0; i < 16; i++) s[i] = v[127 - 8 * i -: 8];
		for (int step = 0; step <= 10; step++) begin
			r = inverse ? 10 - step : step;
			// key add
			for (int i = 0; i < 16; i++) s[i] ^= rk[r][127 - 8 * i -: 8];
			if (step == 10) break;
			if (inverse) begin
				// inverse mix unless first round, then inverse shift and sub
				if (step > 0)
					for (int c = 0; c < 4; c++) begin
						for (int k = 0; k < 4; k++) m[k] = s[4 * c + k];
						for (int q = 0; q < 4; q++)
							s[4 * c + q] = gf_product(m[q], 8'd14)
								^ gf_product(m[(q + 1) % 4], 8'd11)
								^ gf_product(m[(q + 2) % 4], 8'd13)
								^ gf_product(m[(q + 3) % 4], 8'd9);
					end
				for (int q = 0; q < 4; q++)
					for (int c = 0; c < 4; c++) t[q + 4 * ((c + q) % 4)] = isb[s[q + 4 * c]];
				s = t;
			end else begin
				for (int q = 0; q < 4; q++)
					for (int c = 0; c < 4; c++) t[q + 4 * c] = sb[s[q + 4 * ((c + q) % 4)]];
				s = t;
				if (step < 9)
					for (int c = 0; c < 4; c++) begin
						for (int k = 0; k < 4; k++) m[k] = s[4 * c + k];
						for (int q = 0; q < 4; q++)
							s[4 * c + q] = gf_product(m[q], 8'd2)
								^ gf_product(m[(q + 1) % 4], 8'd3)
								^ m[(q + 2) % 4] ^ m[(q + 3) % 4];
					end
			end
		end
		for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = s[i];
		return o;
	endfunction

	function automatic logic [127:0] predict_block(input blk_req_t b);
		logic [127:0] din, dout;
		din = {b.hi, b.lo};
		if (b.first) chain_q = iv_q;
		if (!dec_q) begin
			dout = cipher_block(cbc_q ? din ^ chain_q : din, 1'b0);
			chain_q = dout;
		end else begin
			dout = cipher_block(din, 1'b1);
			if (cbc_q) dout ^= chain_q;
			chain_q = din;
		end
		return dout;
	endfunction

	// append one request to the driver's queue
	task automatic queue_block(input blk_req_t b);
		pending_blocks.insert(pending_blocks.size(), b);
	endtask

	// write one register; drive at the clock edge and mirror in the predictor
	task automatic write_reg(input aes_pkg::cfg_idx_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			aes_pkg::CFG_KEY_HIGH: begin key_q[127:64] = val; expand_round_keys(); end
			aes_pkg::CFG_KEY_LOW:  begin key_q[63:0] = val; expand_round_keys(); end
			aes_pkg::CFG_IV_HIGH:  iv_q[127:64] = val;
			aes_pkg::CFG_IV_LOW:   iv_q[63:0] = val;
			aes_pkg::CFG_MODE:     cbc_q = val[0];
			aes_pkg::CFG_DIR:      dec_q = val[0];
			default: ;
		endcase
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick64();
		case ($urandom_range(0, 7))
			0: return 64'h0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	task automatic drain();
		while (pending_blocks.size() != 0 || expected_blocks.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// driver
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_blocks.insert(expected_blocks.size(),
					predict_block(pending_blocks.pop_front()));
				n_sent++;
				src_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
			end
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (!(s_tvalid && !s_tready) || pending_blocks.size() != 0) begin
				if (pending_blocks.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {pending_blocks[0].lo, pending_blocks[0].hi};
					s_tuser <= pending_blocks[0].first;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int sink_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_blocks.size() == 0) begin
					$error("unexpected result block %h", m_tdata);
					errors++;
				end else begin
					logic [127:0] exp_blk;
					exp_blk = expected_blocks.pop_front();
					if (m_tdata[63:0] !== exp_blk[127:64]) begin
						$error("result_high: expected %h, got %h", exp_blk[127:64], m_tdata[63:0]);
						errors++;
					end
					if (m_tdata[127:64] !== exp_blk[63:0]) begin
						$error("result_low: expected %h, got %h", exp_blk[63:0], m_tdata[127:64]);
						errors++;
					end
					n_checked++;
				end
				sink_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
			end
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog: cycles without any accepted request, result or config write, counted outside reset
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n) quiet = 0;
		else quiet++;
		if (quiet > 2000) begin
			$display("timeout after %0d idle cycles", quiet);
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		blk_req_t b;
		cfg_we = 1'b0;
		cfg_idx = aes_pkg::CFG_KEY_HIGH;
		cfg_data = '0;
		arst_n = 1'b0;
		key_q = '0;
		iv_q = '0;
		chain_q = '0;
		cbc_q = 1'b0;
		dec_q = 1'b0;
		build_sboxes();
		expand_round_keys();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset key, ECB, then CBC with no first block yet
		queue_block('{64'h0, 64'h0, 1'b0});
		queue_block('{'1, '1, 1'b0});
		queue_block('{64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1});
		drain();
		write_reg(aes_pkg::CFG_MODE, 64'h2 | 64'h1);
		queue_block('{64'h1, 64'h0, 1'b0});
		queue_block('{64'h0, 64'h8000000000000000, 1'b0});
		drain();
		// FIPS-197 key, CBC encrypt then decrypt, all-ones IV
		write_reg(aes_pkg::CFG_KEY_HIGH, 64'h0001020304050607);
		write_reg(aes_pkg::CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		write_reg(aes_pkg::CFG_IV_HIGH, '1);
		write_reg(aes_pkg::CFG_IV_LOW, '1);
		for (int i = 0; i < 4; i++) queue_block('{rand64(), rand64(), i == 0});
		drain();
		write_reg(aes_pkg::CFG_DIR, '1);
		write_reg(aes_pkg::CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		for (int i = 0; i < 4; i++) queue_block('{rand64(), rand64(), i == 0});
		drain();
		write_reg(aes_pkg::CFG_MODE, 64'h0);
		queue_block('{64'h00112233445566, 64'h8899aabbccddeeff, 1'b1});
		queue_block('{'1, 64'h0, 1'b0});
		// unknown index is ignored
		drain();
		write_reg(aes_pkg::cfg_idx_t'(3'd7), '1);
		queue_block('{64'h0, '1, 1'b0});
		drain();

		// long receiver stall while the sender keeps offering
		hold_off = 300;
		for (int i = 0; i < 8; i++) queue_block('{rand64(), rand64(), i == 0});
		drain();

		// random phases: fresh settings, then messages of random length
		for (int ph = 0; ph < 15; ph++) begin
			if ($urandom_range(0, 1)) write_reg(aes_pkg::CFG_KEY_HIGH, pick64());
			if ($urandom_range(0, 1)) write_reg(aes_pkg::CFG_KEY_LOW, pick64());
			write_reg(aes_pkg::CFG_IV_HIGH, pick64());
			write_reg(aes_pkg::CFG_IV_LOW, pick64());
			write_reg(aes_pkg::CFG_MODE, rand64());
			write_reg(aes_pkg::CFG_DIR, rand64());
			for (int i = 0; i < 100; i++) begin
				b.hi = pick64();
				b.lo = pick64();
				b.first = $urandom_range(0, 7) == 0;
				queue_block(b);
			end
			drain();
		end

		$display("sent %0d blocks, checked %0d results over ECB/CBC, both directions",
			n_sent, n_checked);
		if (errors == 0 && expected_blocks.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
